// ===== hdl/npcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package npcm_pkg;

	localparam int COLOR_W   = 24;
	localparam int CHAN_W    = 8;
	localparam int IDX_W     = 4;
	localparam int IDX_CMP_W = 7;
	localparam int DIST_W    = 18;
	localparam int LUMA_W    = 16;

	localparam logic [1:0] MODE_FULL    = 2'd0;
	localparam logic [1:0] MODE_REDUCED = 2'd1;
	localparam logic [1:0] MODE_ONEBIT  = 2'd2;

	localparam int PAPER_ENTRY = 1;
	localparam int INK_ENTRY   = 2;

	localparam logic [LUMA_W-1:0] LUMA_R_WT = 16'd77;
	localparam logic [LUMA_W-1:0] LUMA_G_WT = 16'd150;
	localparam logic [LUMA_W-1:0] LUMA_B_WT = 16'd29;
	localparam logic [CHAN_W-1:0] LUMA_THRESH = 8'd128;
	localparam logic [CHAN_W-1:0] CHAN_MASK   = 8'hFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_WAIT,
		ST_LUMA,
		ST_ONE_OUT
	} npcm_state_t;

	// tag travelling alongside a palette word through the distance pipe
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} npcm_tag_t;

endpackage

`default_nettype wire

// ===== hdl/npcm_palette_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module npcm_palette_ram #(
	parameter int DEPTH = 15,
	parameter int AW    = 4
) (
	input  wire                          clk,
	input  wire                          we,
	input  wire  [AW-1:0]                waddr,
	input  wire  [npcm_pkg::COLOR_W-1:0] wdata,
	input  wire                          re,
	input  wire  [AW-1:0]                raddr,
	output logic [npcm_pkg::COLOR_W-1:0] rdata
);
	import npcm_pkg::*;

	logic [COLOR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/npcm_dist_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module npcm_dist_unit (
	input  wire                          clk,
	input  wire                          arst_n,
	input  npcm_pkg::npcm_tag_t          tag_i,
	input  wire  [npcm_pkg::COLOR_W-1:0] entry_i,
	input  wire  [npcm_pkg::COLOR_W-1:0] colour_i,
	output logic                         done_o,
	output logic [npcm_pkg::COLOR_W-1:0] best_o
);
	import npcm_pkg::*;

	npcm_tag_t          tag_s1, tag_s2;
	logic [CHAN_W-1:0]  dr_s1, dg_s1, db_s1;
	logic [COLOR_W-1:0] p_s1, p_s2;
	logic [2*CHAN_W-1:0] sr_s2, sg_s2, sb_s2;
	logic [DIST_W-1:0]  bestd_q;
	logic [COLOR_W-1:0] best_q;
	logic [DIST_W-1:0]  dist_sum;
	logic               take;

	function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
	                                              input logic [CHAN_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			done_o <= 1'b0;
		end else begin
			tag_s1 <= tag_i;
			tag_s2 <= tag_s1;
			done_o <= tag_s2.vld & tag_s2.last;
		end
	end

	// stage 1: channel differences, stage 2: squares
	always_ff @(posedge clk) begin
		dr_s1 <= absdiff(colour_i[7:0] & CHAN_MASK, entry_i[7:0]);
		dg_s1 <= absdiff(colour_i[15:8] & CHAN_MASK, entry_i[15:8]);
		db_s1 <= absdiff(colour_i[23:16] & CHAN_MASK, entry_i[23:16]);
		p_s1  <= entry_i;
		sr_s2 <= {8'd0, dr_s1} * {8'd0, dr_s1};
		sg_s2 <= {8'd0, dg_s1} * {8'd0, dg_s1};
		sb_s2 <= {8'd0, db_s1} * {8'd0, db_s1};
		p_s2  <= p_s1;
	end

	assign dist_sum = {2'b00, sr_s2} + {2'b00, sg_s2} + {2'b00, sb_s2};
	// strict less keeps the lowest index on a tie
	assign take = tag_s2.first | (dist_sum < bestd_q);

	always_ff @(posedge clk) begin
		if (tag_s2.vld && take) begin
			bestd_q <= dist_sum;
			best_q  <= p_s2;
		end
		if (tag_s2.vld && tag_s2.last) begin
			best_o <= take ? p_s2 : best_q;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/nearest_palette_color_map_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Nearest palette colour mapper.
// Command channel: a word (kind, entry_index, color_in) is taken at a rising
// edge with start high and busy low. A load word (kind 1) writes one palette
// entry in that cycle and gives no result; an index past the palette is
// dropped. A convert word gives one result on color_out, marked by done for
// exactly one cycle; the receiver cannot stall, so the word is gone after it.
// The user must write depth_mode through cfg_wr_en / cfg_wr_data only while
// busy is low; the block itself does not enforce it. Load, full colour and
// unused mode words leave busy low, so the next word may follow at once, and
// done marks a full colour result in the cycle after accept. A one-bit ink or
// paper word takes luma, one palette read and the result register. A reduced
// word is paced by the single distance pipe that sees one palette entry per
// cycle through the RAM read port, plus its 3-stage fill and result register.
// Reset clears the sequencer, done and depth_mode (full colour); the palette
// holds nothing until loaded and has no clearing pass.
module nearest_palette_color_map_core #(
	parameter int PALETTE_ENTRIES = 15
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire                          kind,
	input  wire  [npcm_pkg::IDX_W-1:0]   entry_index,
	input  wire  [npcm_pkg::COLOR_W-1:0] color_in,
	output logic                         done,
	output logic [npcm_pkg::COLOR_W-1:0] color_out,
	input  wire                          cfg_wr_en,
	input  wire  [1:0]                   cfg_wr_data
);
	import npcm_pkg::*;

	localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [AW-1:0] LAST_ADDR  = AW'(PALETTE_ENTRIES - 1);
	localparam logic [AW-1:0] INK_ADDR   = AW'(INK_ENTRY);
	localparam logic [AW-1:0] PAPER_ADDR = AW'(PAPER_ENTRY);
	localparam bit INK_PRESENT = (PALETTE_ENTRIES > INK_ENTRY);

	npcm_state_t state_q, state_d;
	logic [1:0]         depth_mode_q;
	logic [COLOR_W-1:0] colour_q;
	logic [AW-1:0]      addr_q;
	logic               dark_q;
	npcm_tag_t          iss_tag_q, iss_tag_d;

	logic               accept, conv_accept;
	logic [IDX_CMP_W-1:0] idx_ext;
	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [COLOR_W-1:0] ram_rdata;
	logic [LUMA_W-1:0]  luma_sum;
	logic               dark;
	logic               out_ld;
	logic [COLOR_W-1:0] out_val;
	logic               dist_done;
	logic [COLOR_W-1:0] dist_best;

	assign busy        = (state_q != ST_IDLE);
	assign accept      = start & ~busy;
	assign conv_accept = accept & ~kind;
	assign idx_ext     = {{(IDX_CMP_W-IDX_W){1'b0}}, entry_index};
	assign ram_we      = accept & kind & (idx_ext < IDX_CMP_W'(PALETTE_ENTRIES));

	assign luma_sum = {8'd0, colour_q[7:0]}   * LUMA_R_WT
	                + {8'd0, colour_q[15:8]}  * LUMA_G_WT
	                + {8'd0, colour_q[23:16]} * LUMA_B_WT;
	assign dark = (luma_sum[15:8] < LUMA_THRESH);

	npcm_palette_ram #(
		.DEPTH (PALETTE_ENTRIES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_ext[AW-1:0]),
		.wdata (color_in),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	npcm_dist_unit u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_i    (iss_tag_q),
		.entry_i  (ram_rdata),
		.colour_i (colour_q),
		.done_o   (dist_done),
		.best_o   (dist_best)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (conv_accept) begin
					if (depth_mode_q == MODE_REDUCED) begin
						state_d = ST_SWEEP;
					end else if (depth_mode_q == MODE_ONEBIT) begin
						state_d = ST_LUMA;
					end
				end
			end
			ST_SWEEP: begin
				if (addr_q == LAST_ADDR) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (dist_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_LUMA:    state_d = ST_ONE_OUT;
			ST_ONE_OUT: state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = addr_q;
		iss_tag_d = '0;
		out_ld    = 1'b0;
		out_val   = dist_best;
		unique case (state_q)
			ST_IDLE: begin
				// full colour and the unused mode pass straight through
				if (conv_accept && depth_mode_q != MODE_REDUCED &&
				    depth_mode_q != MODE_ONEBIT) begin
					out_ld  = 1'b1;
					out_val = color_in;
				end
			end
			ST_SWEEP: begin
				ram_re          = 1'b1;
				iss_tag_d.vld   = 1'b1;
				iss_tag_d.first = (addr_q == '0);
				iss_tag_d.last  = (addr_q == LAST_ADDR);
			end
			ST_WAIT: begin
				out_ld = dist_done;
			end
			ST_LUMA: begin
				ram_re    = 1'b1;
				ram_raddr = dark ? INK_ADDR : PAPER_ADDR;
			end
			ST_ONE_OUT: begin
				out_ld  = 1'b1;
				// with two entries or fewer there is no ink and it reads as black
				out_val = (dark_q && !INK_PRESENT) ? '0 : ram_rdata;
			end
			default: begin
				out_ld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			depth_mode_q <= MODE_FULL;
			iss_tag_q    <= '0;
			addr_q       <= '0;
			done         <= 1'b0;
		end else begin
			state_q   <= state_d;
			iss_tag_q <= iss_tag_d;
			done      <= out_ld;
			if (cfg_wr_en) begin
				depth_mode_q <= cfg_wr_data;
			end
			if (state_q == ST_SWEEP) begin
				addr_q <= AW'(addr_q + 1'b1);
			end else begin
				addr_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (conv_accept) begin
			colour_q <= color_in;
		end
		if (state_q == ST_LUMA) begin
			dark_q <= dark;
		end
		if (out_ld) begin
			color_out <= out_val;
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word issued while busy");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind) |=> !done)
		else $error("load word produced a result");

	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(conv_accept && depth_mode_q != MODE_REDUCED && depth_mode_q != MODE_ONEBIT)
		|=> (done && color_out == $past(color_in)))
		else $error("passthrough result missing or wrong");

	a_dist_wait: assert property (@(posedge clk) disable iff (!arst_n)
		dist_done |-> (state_q == ST_WAIT))
		else $error("distance pipe finished outside a sweep");

	a_onebit_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LUMA) |=> (state_q == ST_ONE_OUT) ##1 done)
		else $error("one-bit word did not complete");

endmodule

`default_nettype wire

// ===== bench/nearest_palette_color_map_core_tb.sv =====
`timescale 1ns / 1ps

module nearest_palette_color_map_core_tb;
	import npcm_pkg::*;

	localparam int PAL_N       = 15;
	localparam int RANDOM_WORDS = 900;
	localparam int SETTLE      = PAL_N + 8;
	localparam int CYCLE_LIMIT = 200000;

	localparam logic       KIND_CONVERT = 1'b0;
	localparam logic       KIND_LOAD    = 1'b1;
	localparam logic [1:0] MODE_SPARE   = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic               kind;
		logic [IDX_W-1:0]   idx;
		logic [COLOR_W-1:0] color;
		logic               typed;
		logic [COLOR_W-1:0] want;
	} step_row_t;

	localparam int N_STEPS = 23;

	// palette set up here: 0 black, 1 paper white, 2 ink, 13/14 equidistant pair
	step_row_t steps [N_STEPS] = '{
		'{MODE_FULL,    KIND_CONVERT, 4'd0,  24'h000000, 1'b1, 24'h000000},
		'{MODE_FULL,    KIND_CONVERT, 4'd15, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
		'{MODE_FULL,    KIND_LOAD,    4'd0,  24'h000000, 1'b0, 24'h000000},
		'{MODE_FULL,    KIND_LOAD,    4'd1,  24'hFFFFFF, 1'b0, 24'h000000},
		'{MODE_FULL,    KIND_LOAD,    4'd2,  24'h100804, 1'b0, 24'h000000},
		'{MODE_FULL,    KIND_LOAD,    4'd3,  24'h0000F0, 1'b0, 24'h000000},
		'{MODE_FULL,    KIND_LOAD,    4'd4,  24'h00F000, 1'b0, 24'h000000},
		'{MODE_FULL,    KIND_LOAD,    4'd5,  24'hF00000, 1'b0, 24'h000000},
		'{MODE_FULL,    KIND_LOAD,    4'd6,  24'h808080, 1'b0, 24'h000000},
		'{MODE_FULL,    KIND_LOAD,    4'd7,  24'h00A0A0, 1'b0, 24'h000000},
		'{MODE_FULL,    KIND_LOAD,    4'd8,  24'hA000A0, 1'b0, 24'h000000},
		'{MODE_FULL,    KIND_LOAD,    4'd9,  24'hA0A000, 1'b0, 24'h000000},
		'{MODE_FULL,    KIND_LOAD,    4'd10, 24'h3070C0, 1'b0, 24'h000000},
		'{MODE_FULL,    KIND_LOAD,    4'd11, 24'hC07030, 1'b0, 24'h000000},
		'{MODE_FULL,    KIND_LOAD,    4'd12, 24'hE0E0E0, 1'b0, 24'h000000},
		'{MODE_FULL,    KIND_LOAD,    4'd13, 24'h606000, 1'b0, 24'h000000},
		'{MODE_FULL,    KIND_LOAD,    4'd14, 24'h600060, 1'b0, 24'h000000},
		'{MODE_FULL,    KIND_LOAD,    4'd15, 24'h123456, 1'b0, 24'h000000},
		'{MODE_ONEBIT,  KIND_CONVERT, 4'd3,  24'h7F7F7F, 1'b1, 24'h100804},
		'{MODE_ONEBIT,  KIND_CONVERT, 4'd9,  24'h808080, 1'b1, 24'hFFFFFF},
		'{MODE_REDUCED, KIND_CONVERT, 4'd5,  24'h808080, 1'b1, 24'h808080},
		'{MODE_REDUCED, KIND_CONVERT, 4'd6,  24'h603030, 1'b0, 24'h000000},
		'{MODE_SPARE,   KIND_CONVERT, 4'd10, 24'h5A3CC3, 1'b1, 24'h5A3CC3}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               kind = KIND_CONVERT;
	logic [IDX_W-1:0]   entry_index = '0;
	logic [COLOR_W-1:0] color_in = '0;
	logic               done;
	logic [COLOR_W-1:0] color_out;
	logic               cfg_wr_en = 1'b0;
	logic [1:0]         cfg_wr_data = MODE_FULL;

	logic [COLOR_W-1:0] pal_model [PAL_N];
	logic [1:0]         depth_q = MODE_FULL;
	logic [COLOR_W-1:0] pending_pixels [$];

	int mismatch_count = 0;
	int checked_pixels = 0;
	int convert_words  = 0;
	int load_words     = 0;
	int mode_writes    = 0;
	int burst_left     = 0;
	int cycle_count    = 0;

	nearest_palette_color_map_core #(
		.PALETTE_ENTRIES(PAL_N)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.entry_index(entry_index),
		.color_in   (color_in),
		.done       (done),
		.color_out  (color_out),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int sq_chan(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
		int d;
		d = int'(a) - int'(b);
		return d * d;
	endfunction

	// expected pixel for a convert word under the current depth setting
	function automatic logic [COLOR_W-1:0] recolour(input logic [COLOR_W-1:0] c);
		int best_d;
		int d;
		int luma;
		logic [COLOR_W-1:0] best;
		best = pal_model[0];
		best_d = 32'h7FFF_FFFF;
		case (depth_q)
			MODE_REDUCED: begin
				// strict less-than keeps the lowest index on a tie
				for (int i = 0; i < PAL_N; i++) begin
					d = sq_chan(c[7:0], pal_model[i][7:0])
						+ sq_chan(c[15:8], pal_model[i][15:8])
						+ sq_chan(c[23:16], pal_model[i][23:16]);
					if (d < best_d) begin
						best_d = d;
						best = pal_model[i];
					end
				end
				return best;
			end
			MODE_ONEBIT: begin
				luma = (int'(c[7:0]) * int'(LUMA_R_WT) + int'(c[15:8]) * int'(LUMA_G_WT)
					+ int'(c[23:16]) * int'(LUMA_B_WT)) >> 8;
				return (luma < int'(LUMA_THRESH)) ? pal_model[INK_ENTRY] : pal_model[PAPER_ENTRY];
			end
			default: return c;
		endcase
	endfunction

	function automatic logic [COLOR_W-1:0] pick_color();
		logic [COLOR_W-1:0] c;
		logic [CHAN_W-1:0] g;
		int v;
		c = COLOR_W'($urandom);
		case ($urandom_range(0, 5))
			1: begin
				for (int k = 0; k < 3; k++)
					c[8*k +: 8] = $urandom_range(0, 1) ? CHAN_MASK : 8'h00;
			end
			2: begin
				// close to an entry, so the nearest search is tight
				c = pal_model[$urandom_range(0, PAL_N - 1)];
				for (int k = 0; k < 3; k++) begin
					v = int'(c[8*k +: 8]) + int'($urandom_range(0, 16)) - 8;
					if (v < 0) v = 0;
					if (v > 255) v = 255;
					c[8*k +: 8] = CHAN_W'(v);
				end
			end
			3: begin
				// grey around the ink/paper threshold
				g = CHAN_W'($urandom_range(120, 136));
				c = {g, g, g};
			end
			4: c = pal_model[$urandom_range(0, PAL_N - 1)];
			default: ;
		endcase
		return c;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				$error("color_out: unexpected word, expected none, got %06h", color_out);
				mismatch_count++;
			end else begin
				checked_pixels++;
				if (color_out !== pending_pixels[0]) begin
					$error("color_out: expected %06h, got %06h", pending_pixels[0], color_out);
					mismatch_count++;
				end
				void'(pending_pixels.pop_front());
			end
		end
	end

	// called at a clock edge; returns at the edge that takes the word
	task automatic put_word(input logic k, input logic [IDX_W-1:0] idx,
		input logic [COLOR_W-1:0] c, input logic typed, input logic [COLOR_W-1:0] want);
		start <= 1'b1;
		kind <= k;
		entry_index <= idx;
		color_in <= c;
		do @(posedge clk); while (busy);
		if (k == KIND_LOAD) begin
			load_words++;
			if (int'(idx) < PAL_N)
				pal_model[idx] = c;
		end else begin
			convert_words++;
			pending_pixels.push_back(typed ? want : recolour(c));
		end
	endtask

	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 25)) @(posedge clk);
			burst_left = $urandom_range(0, 30);
		end
	endtask

	// only while idle: drain, let a trailing load or sweep finish, then write
	task automatic set_depth(input logic [1:0] m);
		start <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		while (busy) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		depth_q = m;
		mode_writes++;
	endtask

	initial begin
		logic [1:0] phase_mode;
		logic [1:0] first_modes [4];
		int phase;
		int random_words;
		int phase_len;
		logic k;
		logic [IDX_W-1:0] idx;

		first_modes = '{MODE_ONEBIT, MODE_REDUCED, MODE_SPARE, MODE_FULL};
		for (int i = 0; i < PAL_N; i++)
			pal_model[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].mode != depth_q)
				set_depth(steps[i].mode);
			put_word(steps[i].kind, steps[i].idx, steps[i].color, steps[i].typed, steps[i].want);
			pace();
		end

		// every entry is loaded by now, so any mode may read the palette
		phase = 0;
		random_words = 0;
		while (random_words < RANDOM_WORDS) begin
			phase_mode = (phase < 4) ? first_modes[phase] : 2'($urandom_range(0, 3));
			set_depth(phase_mode);
			phase_len = $urandom_range(20, 90);
			for (int n = 0; n < phase_len; n++) begin
				k = ($urandom_range(0, 4) == 0) ? KIND_LOAD : KIND_CONVERT;
				idx = IDX_W'($urandom_range(0, 15));
				put_word(k, idx, pick_color(), 1'b0, '0);
				if (!(k == KIND_LOAD && int'(idx) >= PAL_N))
					random_words++;
				pace();
			end
			phase++;
		end

		start <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Covered %0d colour words and %0d palette loads across %0d depth mode writes",
			convert_words, load_words, mode_writes);
		$display("%0d recoloured pixels compared", checked_pixels);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/npcm_pkg.sv
hdl/npcm_palette_ram.sv
hdl/npcm_dist_unit.sv
hdl/nearest_palette_color_map_core.sv
bench/nearest_palette_color_map_core_tb.sv
